>>> src/rqa_pkg.sv
// ----------------------------------------------------------------------------
// rqa_pkg
// Shared types and constants for the ready queue with least-priority
// selection and aging.
// ----------------------------------------------------------------------------
package rqa_pkg;

    localparam int QUEUE_DEPTH   = 10;
    localparam int PROCESS_COUNT = 32;

    localparam int KIND_W = 2;
    localparam int ID_W   = 5;
    localparam int PRIO_W = 7;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MARK_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AGE    = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_READY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   process_id;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic              removed_valid;
        logic [ID_W-1:0]   removed_id;
        logic [PRIO_W-1:0] removed_priority;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [PRIO_W-1:0] prio;
    } slot_t;

endpackage

>>> src/ready_queue_min_select_aging.sv
// ----------------------------------------------------------------------------
// ready_queue_min_select_aging
// Ready queue of process slots with heap-pass removal and priority aging.
// ----------------------------------------------------------------------------
// One command is worked on at a time and gives exactly one result beat. A
// remove runs a heap pass that visits each internal node through the slot
// memory, which has one write port, and one shared comparator. An age reads
// each queued slot and writes it back only where its priority is above 1.
// A new command is taken as soon as the previous one has left for the
// output register, even while that result still waits to be taken.
module ready_queue_min_select_aging
    import rqa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_CH_RD  = 4'd2;
    localparam logic [3:0] S_ND_RD  = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;
    localparam logic [3:0] S_SWAP   = 4'd5;
    localparam logic [3:0] S_POP_RD = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_AGE_RD = 4'd8;
    localparam logic [3:0] S_AGE_WR = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    localparam int WIDE_W = CNT_W + 1;

    logic [3:0]               state_reg, state_next;
    cmd_t                     item_reg, item_next;
    res_t                     pend_reg, pend_next;
    res_t                     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [PROCESS_COUNT-1:0] ready_reg, ready_next;
    logic [ADDR_W-1:0]        r_reg, r_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        pick_reg, pick_next;
    slot_t                    pick_data_reg, pick_data_next;

    slot_t             mem [QUEUE_DEPTH];
    slot_t             rd_a_reg, rd_b_reg;
    logic              rd_a_en, rd_b_en, wr_en;
    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
    slot_t             wr_data;

    // Shared comparator: computes cmp_a < cmp_b for whichever state uses it.
    logic [PRIO_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic [ADDR_W-1:0] front, node_addr, left_addr, right_addr;
    logic [WIDE_W-1:0] right_off;
    logic              has_right;
    logic              id_in_range, rm_in_range;
    logic [MARK_W-1:0] id_mark, rm_mark;
    logic              out_free;

    assign cmp_lt = cmp_a < cmp_b;

    assign front      = ADDR_W'(CNT_W'(QUEUE_DEPTH) - fill_reg);
    assign node_addr  = front + r_reg;
    assign left_addr  = front + ADDR_W'({r_reg, 1'b1});
    assign right_off  = WIDE_W'({r_reg, 1'b0}) + WIDE_W'(2);
    assign has_right  = right_off < WIDE_W'(fill_reg);
    assign right_addr = has_right ? left_addr + ADDR_W'(1) : left_addr;

    assign id_in_range = 32'(item_reg.process_id) < 32'(PROCESS_COUNT);
    assign id_mark     = MARK_W'(item_reg.process_id);
    assign rm_in_range = 32'(rd_a_reg.ident) < 32'(PROCESS_COUNT);
    assign rm_mark     = MARK_W'(rd_a_reg.ident);

    assign out_free  = !out_valid_reg || !res_stall;
    assign cmd_stall = state_reg != S_IDLE;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fill_next      = fill_reg;
        ready_next     = ready_reg;
        r_next         = r_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        pick_data_next = pick_data_reg;
        rd_a_en        = 1'b0;
        rd_b_en        = 1'b0;
        rd_a_addr      = node_addr;
        rd_b_addr      = right_addr;
        wr_en          = 1'b0;
        wr_addr        = node_addr;
        wr_data        = pick_data_reg;
        cmp_a          = rd_a_reg.prio;
        cmp_b          = rd_b_reg.prio;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_next  = '0;
                state_next = S_FINISH;
                case (item_reg.kind)
                    KIND_INSERT:
                    begin
                        if (!id_in_range || ready_reg[id_mark])
                        begin
                            pend_next.status = STATUS_READY;
                        end
                        else if (fill_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            pend_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en               = 1'b1;
                            wr_addr             = ADDR_W'(CNT_W'(QUEUE_DEPTH - 1) - fill_reg);
                            wr_data.ident       = item_reg.process_id;
                            wr_data.prio        = item_reg.priority_req;
                            ready_next[id_mark] = 1'b1;
                            fill_next           = fill_reg + CNT_W'(1);
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (fill_reg == '0)
                        begin
                            pend_next.status = STATUS_EMPTY;
                        end
                        else if (fill_reg >= CNT_W'(2))
                        begin
                            r_next     = ADDR_W'((fill_reg >> 1) - CNT_W'(1));
                            state_next = S_CH_RD;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                    KIND_AGE:
                    begin
                        if (fill_reg != '0)
                        begin
                            idx_next   = front;
                            state_next = S_AGE_RD;
                        end
                    end
                    default:
                    begin
                        pend_next.status = STATUS_OK;
                    end
                endcase
            end
            S_CH_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = left_addr;
                rd_b_en    = 1'b1;
                rd_b_addr  = right_addr;
                state_next = S_ND_RD;
            end
            S_ND_RD:
            begin
                // A tie goes to the right child; a lone left child is taken as is.
                if (!has_right || cmp_lt)
                begin
                    pick_next      = left_addr;
                    pick_data_next = rd_a_reg;
                end
                else
                begin
                    pick_next      = right_addr;
                    pick_data_next = rd_b_reg;
                end
                rd_a_en    = 1'b1;
                rd_a_addr  = node_addr;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmp_a = pick_data_reg.prio;
                cmp_b = rd_a_reg.prio;
                if (cmp_lt)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = node_addr;
                    wr_data    = pick_data_reg;
                    state_next = S_SWAP;
                end
                else if (r_reg == '0)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    r_next     = r_reg - ADDR_W'(1);
                    state_next = S_CH_RD;
                end
            end
            S_SWAP:
            begin
                // The old node entry is still held in the port A read register.
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = rd_a_reg;
                if (r_reg == '0)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    r_next     = r_reg - ADDR_W'(1);
                    state_next = S_CH_RD;
                end
            end
            S_POP_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = front;
                state_next = S_POP;
            end
            S_POP:
            begin
                pend_next.removed_valid    = 1'b1;
                pend_next.removed_id       = rd_a_reg.ident;
                pend_next.removed_priority = rd_a_reg.prio;
                pend_next.status           = STATUS_OK;
                if (rm_in_range)
                begin
                    ready_next[rm_mark] = 1'b0;
                end
                fill_next  = fill_reg - CNT_W'(1);
                state_next = S_FINISH;
            end
            S_AGE_RD:
            begin
                rd_a_en    = 1'b1;
                rd_a_addr  = idx_reg;
                state_next = S_AGE_WR;
            end
            S_AGE_WR:
            begin
                cmp_a = PRIO_W'(1);
                cmp_b = rd_a_reg.prio;
                if (cmp_lt)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg;
                    wr_data.ident = rd_a_reg.ident;
                    wr_data.prio  = rd_a_reg.prio - PRIO_W'(1);
                end
                if (idx_reg == ADDR_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_AGE_RD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_next           = pend_reg;
                    out_next.occupancy = OCC_W'(fill_reg);
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            ready_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            ready_reg     <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        r_reg         <= r_next;
        idx_reg       <= idx_next;
        pick_reg      <= pick_next;
        pick_data_reg <= pick_data_next;
    end

    // Slot memory: one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

endmodule

>>> tb/sv/rqa_outcome_checker.sv
// ----------------------------------------------------------------------------
// rqa_outcome_checker
// Watches both channels of the ready queue, keeps its own model of the
// slots, the fill level and the ready marks, works out the result of every
// accepted command and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module rqa_outcome_checker
    import rqa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  logic  cmd_stall,
    input  cmd_t  cmd,
    input  logic  res_valid,
    input  logic  res_stall,
    input  res_t  res,
    output int    fail_count,
    output int    pending,
    output int    beats_checked,
    output int    removals,
    output int    rejects
);

    timeunit 1ns;
    timeprecision 1ps;

    slot_t q_slot [QUEUE_DEPTH];
    bit    is_ready [PROCESS_COUNT];
    int    q_fill;
    res_t  outcome_q [$];

    // Applies one command to the model state and returns the result it gives.
    function automatic res_t predict_outcome(input cmd_t c);
        res_t  r;
        slot_t tmp;
        int    front;
        int    node;
        int    lchild;
        int    rchild;
        int    pick;
        int    k;
        r = '0;
        r.status = STATUS_OK;
        case (c.kind)
            KIND_INSERT:
            begin
                if (int'(c.process_id) >= PROCESS_COUNT || is_ready[c.process_id])
                begin
                    r.status = STATUS_READY;
                end
                else if (q_fill >= QUEUE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    q_slot[QUEUE_DEPTH - 1 - q_fill].ident = c.process_id;
                    q_slot[QUEUE_DEPTH - 1 - q_fill].prio  = c.priority_req;
                    is_ready[c.process_id] = 1'b1;
                    q_fill++;
                end
            end
            KIND_REMOVE:
            begin
                if (q_fill == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    front = QUEUE_DEPTH - q_fill;
                    // Bottom-up pass from the last internal node to the root;
                    // on equal children the right one is taken.
                    for (k = q_fill / 2 - 1; k >= 0; k--)
                    begin
                        node   = front + k;
                        lchild = front + 2 * k + 1;
                        rchild = lchild + 1;
                        if (2 * k + 2 >= q_fill)
                            pick = lchild;
                        else if (q_slot[lchild].prio < q_slot[rchild].prio)
                            pick = lchild;
                        else
                            pick = rchild;
                        if (q_slot[pick].prio < q_slot[node].prio)
                        begin
                            tmp          = q_slot[pick];
                            q_slot[pick] = q_slot[node];
                            q_slot[node] = tmp;
                        end
                    end
                    r.removed_valid    = 1'b1;
                    r.removed_id       = q_slot[front].ident;
                    r.removed_priority = q_slot[front].prio;
                    if (int'(q_slot[front].ident) < PROCESS_COUNT)
                        is_ready[q_slot[front].ident] = 1'b0;
                    q_slot[front] = '0;
                    q_fill--;
                end
            end
            KIND_AGE:
            begin
                for (k = QUEUE_DEPTH - q_fill; k < QUEUE_DEPTH; k++)
                begin
                    if (q_slot[k].prio > 1)
                        q_slot[k].prio = q_slot[k].prio - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(q_fill);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            foreach (q_slot[i])
                q_slot[i] = '0;
            foreach (is_ready[i])
                is_ready[i] = 1'b0;
            q_fill = 0;
            outcome_q.delete();
            fail_count    = 0;
            beats_checked = 0;
            removals      = 0;
            rejects       = 0;
        end
        else
        begin
            // The result side is handled first: a beat leaving at this edge
            // always belongs to an older command than one accepted here.
            if (res_valid && !res_stall)
            begin
                got = res;
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", got);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    beats_checked++;
                    check_field("removed_valid", 8'(want.removed_valid),
                                8'(got.removed_valid));
                    check_field("removed_id", 8'(want.removed_id), 8'(got.removed_id));
                    check_field("removed_priority", 8'(want.removed_priority),
                                8'(got.removed_priority));
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                want = predict_outcome(cmd);
                if (want.removed_valid)
                    removals++;
                if (want.status != STATUS_OK)
                    rejects++;
                outcome_q.push_back(want);
            end
        end
        pending = outcome_q.size();
    end

endmodule

>>> tb/sv/tb_ready_queue_min_select_aging.sv
// ----------------------------------------------------------------------------
// tb_ready_queue_min_select_aging
// Drives directed and random scheduler commands into the ready queue with
// random idling on both channels and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_ready_queue_min_select_aging;

    timeunit 1ns;
    timeprecision 1ps;

    import rqa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 1880;
    localparam int CHUNK       = 50;
    localparam int CALM_TAIL   = 300;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    int fail_count;
    int pending;
    int beats_checked;
    int removals;
    int rejects;
    int sent;
    bit idle_on;

    ready_queue_min_select_aging i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    rqa_outcome_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .removals      (removals),
        .rejects       (rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t make_cmd(input logic [KIND_W-1:0] kind,
                                      input int id, input int prio);
        cmd_t c;
        c.kind         = kind;
        c.process_id   = ID_W'(id);
        c.priority_req = PRIO_W'(prio);
        return c;
    endfunction

    // Random command; roughly one in four priorities is tiny to force ties and
    // to let aging reach its floor.
    function automatic cmd_t rand_cmd(input int ins_pct, input int rem_pct);
        cmd_t c;
        int   roll;
        roll = $urandom_range(0, 99);
        c.process_id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
        if ($urandom_range(0, 3) == 0)
            c.priority_req = PRIO_W'($urandom_range(0, 3));
        else
            c.priority_req = PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
        if (roll < ins_pct)
            c.kind = KIND_INSERT;
        else if (roll < ins_pct + rem_pct)
            c.kind = KIND_REMOVE;
        else if (roll < 98)
            c.kind = KIND_AGE;
        else
            c.kind = KIND_UNUSED;
        return c;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic issue(input cmd_t c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic drain();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            res_stall <= 1'b0;
        end
    end

    initial
    begin
        int ins_pct;
        int rem_pct;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        idle_on    = 1'b1;
        sent       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty queue corners, duplicate insert, a full queue
        // with tied priorities, aging, and the unused command code.
        issue(make_cmd(KIND_REMOVE, 0, 0));
        issue(make_cmd(KIND_AGE, 0, 0));
        issue(make_cmd(KIND_UNUSED, 0, 0));
        issue(make_cmd(KIND_INSERT, 0, 127));
        issue(make_cmd(KIND_INSERT, 0, 5));
        issue(make_cmd(KIND_INSERT, 31, 0));
        issue(make_cmd(KIND_INSERT, 1, 1));
        issue(make_cmd(KIND_INSERT, 2, 1));
        issue(make_cmd(KIND_INSERT, 3, 2));
        issue(make_cmd(KIND_INSERT, 4, 2));
        issue(make_cmd(KIND_INSERT, 5, 64));
        issue(make_cmd(KIND_INSERT, 6, 127));
        issue(make_cmd(KIND_INSERT, 7, 3));
        issue(make_cmd(KIND_INSERT, 8, 1));
        issue(make_cmd(KIND_INSERT, 9, 4));
        issue(make_cmd(KIND_INSERT, 31, 9));
        issue(make_cmd(KIND_AGE, 0, 0));
        issue(make_cmd(KIND_AGE, 0, 0));
        issue(make_cmd(KIND_REMOVE, 31, 127));
        issue(make_cmd(KIND_REMOVE, 0, 0));
        issue(make_cmd(KIND_UNUSED, 31, 127));
        issue(make_cmd(KIND_REMOVE, 0, 0));
        drain();

        ins_pct = 45;
        rem_pct = 40;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % CHUNK == 0)
            begin
                // Each stretch leans towards filling, emptying or neither, so
                // the full and empty corners come round again and again.
                case ($urandom_range(0, 2))
                    0:
                    begin
                        ins_pct = 65;
                        rem_pct = 20;
                    end
                    1:
                    begin
                        ins_pct = 30;
                        rem_pct = 55;
                    end
                    default:
                    begin
                        ins_pct = 45;
                        rem_pct = 40;
                    end
                endcase
                idle_on = (n < RANDOM_CMDS - CALM_TAIL) && ($urandom_range(0, 4) != 0);
            end
            if (n == RANDOM_CMDS / 2)
                drain();
            issue(rand_cmd(ins_pct, rem_pct));
        end
        drain();
        repeat (40) @(posedge clk);

        $display("Run covered %0d commands and %0d checked result beats,", sent,
                 beats_checked);
        $display("including %0d removals and %0d rejected or ignored commands.",
                 removals, rejects);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
